[rtl/byte_ring_fifo_with_overrun_core_assert.svh]
// Assertion macros for the byte ring FIFO.
// Each macro samples on the rising edge of clk and is idle while rst_n is low.
`ifndef BYTE_RING_FIFO_WITH_OVERRUN_CORE_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_OVERRUN_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define BRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by a consequence on the next clock edge.
`define BRF_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

[rtl/brf_pkg.sv]
// ----------------------------------------------------------------------------
// Byte ring FIFO package
// Shared widths, opcodes, status codes and the result word type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brf_pkg;

  localparam int RING_BYTES = 256;
  localparam int IDX_W      = $clog2(RING_BYTES);
  localparam int MASK_W     = IDX_W + 1;
  localparam int MAX_LOG2   = (IDX_W > 8) ? 8 : IDX_W;
  localparam int MIN_LOG2   = 2;
  localparam int CAP_W      = 4;
  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  localparam int IN_W  = 16;
  localparam int OUT_W = 32;

  // Opcodes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_PAIR  = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Read data selection for the result word
  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_BYTE = 2'd1;
  localparam logic [1:0] RD_PAIR = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic       overrun_seen;
    logic [7:0] free_slots;
    logic [1:0] status;
    logic [15:0] read_data;
  } result_t;

endpackage

`default_nettype wire

[rtl/byte_ring_fifo_with_overrun_core.sv]
// ----------------------------------------------------------------------------
// Byte ring FIFO with overrun flag
// Power-of-two byte ring with push, pop, pop-pair and flush commands.
// ----------------------------------------------------------------------------
// Usage: each input word carries a command; every command returns exactly one
// result word with read data, status, the free slot count after the command
// and the sticky overrun flag. The block takes one command per clock cycle
// when the result side keeps up: the indices update at the accepting edge and
// the byte store (256 bytes, one write port, two read ports, registered
// read data) is read at that same edge, so the result is valid on the next
// cycle and is held in an output register until taken. While that result
// waits, one more command is taken in the cycle it is accepted on the output.
// The ring size in use is 2**cfg_capacity_log2 bytes, clamped to 4..256, with
// one slot always kept empty. Change the size only when the block is idle.
// A push into a full ring drops the byte and sets the overrun flag; a flush
// empties the ring and clears the flag. The byte store needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_fifo_with_overrun_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Input words
  input  wire logic                       in_tvalid,
  output      logic                       in_tready,
  input  wire logic [brf_pkg::IN_W-1:0]   in_tdata,   // [1:0] opcode, [9:2] data_in
  // Result words
  output      logic                       out_tvalid,
  input  wire logic                       out_tready,
  output      logic [brf_pkg::OUT_W-1:0]  out_tdata,  // [15:0] read_data, [17:16] status,
                                                      // [25:18] free_slots, [26] overrun_seen
  // Configuration
  input  wire logic                       cfg_wr_en,
  input  wire logic [brf_pkg::CAP_W-1:0]  cfg_wr_data // capacity_log2
);

  import brf_pkg::*;

  // State registers
  logic [CAP_W-1:0] cap_r;
  idx_t             wr_idx_r, wr_idx_nxt;
  idx_t             rd_idx_r, rd_idx_nxt;
  logic             ovr_r, ovr_nxt;

  // Byte store and its registered read ports
  logic [7:0] mem [RING_BYTES];
  logic [7:0] rd_a_r, rd_b_r;

  // Output register
  logic       out_valid_r;
  logic [1:0] sel_r, sel_nxt;
  logic [1:0] status_r, status_nxt;
  logic [7:0] free_r, free_nxt;
  logic       ovr_out_r;

  // Command decode
  logic       acc;
  logic [1:0] opcode;
  logic [7:0] data_in;
  logic [CAP_W-1:0] lg;
  idx_t       mask, head, tail, used, head_inc, tail_inc, tail_add2;
  idx_t       head_n, tail_n;
  logic       mem_we;

  assign opcode  = in_tdata[1:0];
  assign data_in = in_tdata[9:2];

  // Take a new word when the output register is free or drains this cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  // Clamp the size register and build the index mask.
  always_comb begin
    if (cap_r < CAP_W'(MIN_LOG2)) begin
      lg = CAP_W'(MIN_LOG2);
    end else if (cap_r > CAP_W'(MAX_LOG2)) begin
      lg = CAP_W'(MAX_LOG2);
    end else begin
      lg = cap_r;
    end
  end

  assign mask      = IDX_W'((MASK_W'(1) << lg) - MASK_W'(1));
  assign head      = wr_idx_r & mask;
  assign tail      = rd_idx_r & mask;
  assign used      = (head - tail) & mask;
  assign head_inc  = (head + idx_t'(1)) & mask;
  assign tail_inc  = (tail + idx_t'(1)) & mask;
  assign tail_add2 = (tail + idx_t'(2)) & mask;

  // Work out the command: new indices, flag, status and what to show as data.
  always_comb begin
    head_n     = head;
    tail_n     = tail;
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    ovr_nxt    = ovr_r;
    status_nxt = ST_OK;
    sel_nxt    = RD_NONE;
    mem_we     = 1'b0;
    case (opcode)
      OP_PUSH: begin
        if (head_inc != tail) begin
          mem_we     = acc;
          head_n     = head_inc;
          wr_idx_nxt = head_inc;
        end else begin
          // Ring full: drop the byte and latch the overrun.
          ovr_nxt    = 1'b1;
          status_nxt = ST_FULL;
        end
      end
      OP_POP: begin
        if (used != '0) begin
          tail_n     = tail_inc;
          rd_idx_nxt = tail_inc;
          sel_nxt    = RD_BYTE;
        end else begin
          status_nxt = ST_EMPTY;
        end
      end
      OP_PAIR: begin
        // Need two stored bytes; otherwise leave the indices as is and report empty.
        if (used >= idx_t'(2)) begin
          tail_n     = tail_add2;
          rd_idx_nxt = tail_add2;
          sel_nxt    = RD_PAIR;
        end else begin
          status_nxt = ST_EMPTY;
        end
      end
      OP_FLUSH: begin
        tail_n     = head;
        rd_idx_nxt = head;
        ovr_nxt    = 1'b0;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
    free_nxt = 8'((tail_n - head_n - idx_t'(1)) & mask);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      ovr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (acc) begin
        wr_idx_r <= wr_idx_nxt;
        rd_idx_r <= rd_idx_nxt;
        ovr_r    <= ovr_nxt;
      end
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: hold until the next accepted word.
  always_ff @(posedge clk) begin
    if (acc) begin
      sel_r     <= sel_nxt;
      status_r  <= status_nxt;
      free_r    <= free_nxt;
      ovr_out_r <= ovr_nxt;
    end
  end

  // Byte store: write the pushed byte, read both head-of-queue bytes on accept.
  // A push also reads the store, so a read can meet a write to the same entry
  // at the same edge; a push result shows no read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[head] <= data_in;
    end
    if (acc) begin
      rd_a_r <= mem[tail];
      rd_b_r <= mem[tail_inc];
    end
  end

  // Assemble the result word.
  result_t res;

  always_comb begin
    res.status       = status_r;
    res.free_slots   = free_r;
    res.overrun_seen = ovr_out_r;
    case (sel_r)
      RD_BYTE: res.read_data = {8'h00, rd_a_r};
      RD_PAIR: res.read_data = {rd_a_r, rd_b_r};
      default: res.read_data = 16'h0000;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W - $bits(result_t))'(0), res};

  // Checks
`include "byte_ring_fifo_with_overrun_core_assert.svh"

  `BRF_ASSERT(a_ovr_rise_on_push, $rose(ovr_r) |-> $past(acc && (opcode == OP_PUSH)), "overrun set without a push")
  `BRF_ASSERT(a_full_shows_ovr, (out_valid_r && (status_r == ST_FULL)) |-> ovr_out_r, "full status without overrun flag")
  `BRF_ASSERT_NEXT(a_flush_result, acc && (opcode == OP_FLUSH), out_valid_r && (status_r == ST_OK) && !ovr_out_r && (sel_r == RD_NONE), "flush result wrong")
  `BRF_ASSERT_NEXT(a_empty_pop_holds, acc && (opcode == OP_POP) && (status_nxt == ST_EMPTY), $stable(rd_idx_r) && (sel_r == RD_NONE), "failed pop moved read index")

endmodule

`default_nettype wire
